### rtl/fegd_pkg.sv
package fegd_pkg;

  localparam int AngleFracBits = 16;
  localparam int DistFracBits  = 8;
  localparam int LatW          = 24;
  localparam int LonW          = 25;
  localparam int DistW         = 23;

  // miles per degree (22*pi) in Q24, degrees to radians in Q32
  localparam logic [30:0] MilesPerDegQ24 = 31'd1159557928;
  localparam logic [26:0] DegToRadQ32    = 27'd74961321;
  localparam logic [30:0] OneQ30         = 31'h4000_0000;
  localparam logic [23:0] QuarterTurn    = 24'(90 << AngleFracBits);
  localparam logic [23:0] HalfTurn       = 24'(180 << AngleFracBits);
  localparam logic [23:0] LegCap         = 24'h80_0000;
  localparam logic [DistW-1:0] DistMax   = '1;

  localparam int NumHorner  = 5;
  localparam int CosLat     = 2 + 3 * NumHorner + 2;
  localparam int SqrtSteps  = 24;
  localparam int NumStages  = CosLat + 4 + SqrtSteps + 1;

  // Horner divisor n = odd << shift, odd part divided by reciprocal floor(2^32/odd)
  typedef struct packed {
    logic [1:0]  shift;
    logic [5:0]  odd;
    logic [30:0] recip;
  } horner_step_t;

  function automatic horner_step_t horner_step(input int idx);
    horner_step_t s;
    unique case (idx)
      0:       s = '{shift: 2'd2, odd: 6'd33, recip: 31'd130150524};
      1:       s = '{shift: 2'd1, odd: 6'd45, recip: 31'd95443717};
      2:       s = '{shift: 2'd3, odd: 6'd7,  recip: 31'd613566756};
      3:       s = '{shift: 2'd1, odd: 6'd15, recip: 31'd286331153};
      default: s = '{shift: 2'd2, odd: 6'd3,  recip: 31'd1431655765};
    endcase
    return s;
  endfunction

endpackage

### rtl/fegd_horner_cell.sv
module fegd_horner_cell (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  fegd_pkg::horner_step_t        step_i,
  input  logic [31:0]                   x2_i,
  input  logic [30:0]                   t_i,
  output logic [31:0]                   x2_o,
  output logic [30:0]                   t_o
);

  logic [31:0] x2_1_q, x2_2_q, x2_3_q;
  logic [31:0] v_q;
  logic [30:0] vs_q, q0_q, t_q;
  logic [62:0] prod;
  logic [30:0] vs;
  logic [61:0] qprod;
  logic [36:0] qm;
  logic [30:0] rem;
  logic [30:0] q;

  always_comb begin
    prod  = 63'(x2_i) * 63'(t_i);
    vs    = 31'(v_q >> step_i.shift);
    qprod = 62'(vs) * 62'(step_i.recip);
    qm    = 37'(q0_q) * 37'(step_i.odd);
    rem   = 31'(37'(vs_q) - qm);
    // estimate is low by at most one
    q     = (rem >= 31'(step_i.odd)) ? q0_q + 31'd1 : q0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_1_q <= x2_i;
      v_q    <= prod[61:30];
      x2_2_q <= x2_1_q;
      vs_q   <= vs;
      q0_q   <= 31'(qprod[61:32]);
      x2_3_q <= x2_2_q;
      t_q    <= fegd_pkg::OneQ30 - q;
    end
  end

  assign x2_o = x2_3_q;
  assign t_o  = t_q;

endmodule

### rtl/fegd_cos.sv
module fegd_cos (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [23:0]            lat_i,
  output logic signed [31:0]            cos_o
);

  logic [23:0] mag;
  logic [22:0] x;
  logic        neg;
  logic [49:0] rprod;
  logic [30:0] r_q;
  logic [61:0] sq;
  logic [31:0] x2_q;
  logic [fegd_pkg::CosLat-2:0] neg_q;

  logic [31:0] x2_c [fegd_pkg::NumHorner+1];
  logic [30:0] t_c  [fegd_pkg::NumHorner+1];

  logic [62:0] fprod;
  logic [31:0] v_q;
  logic [31:0] p;
  logic [30:0] c;
  logic signed [31:0] cos_q;

  always_comb begin
    mag = lat_i[23] ? 24'(-lat_i) : 24'(lat_i);
    // fold into the first quadrant, flip sign for the second
    if (mag > fegd_pkg::QuarterTurn) begin
      x   = 23'(fegd_pkg::HalfTurn - mag);
      neg = 1'b1;
    end else begin
      x   = mag[22:0];
      neg = 1'b0;
    end
    rprod = 50'(x) * 50'(fegd_pkg::DegToRadQ32);
    sq    = 62'(r_q) * 62'(r_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q   <= rprod[48:18];
      x2_q  <= sq[61:30];
      neg_q <= {neg_q[fegd_pkg::CosLat-3:0], neg};
    end
  end

  assign x2_c[0] = x2_q;
  assign t_c[0]  = fegd_pkg::OneQ30;

  for (genvar i = 0; i < fegd_pkg::NumHorner; i++) begin : g_cell
    fegd_horner_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .step_i (fegd_pkg::horner_step(i)),
      .x2_i   (x2_c[i]),
      .t_i    (t_c[i]),
      .x2_o   (x2_c[i+1]),
      .t_o    (t_c[i+1])
    );
  end

  always_comb begin
    fprod = 63'(x2_c[fegd_pkg::NumHorner]) * 63'(t_c[fegd_pkg::NumHorner]);
    p     = v_q >> 1;
    c     = (p >= 32'(fegd_pkg::OneQ30)) ? 31'd0 : 31'(32'(fegd_pkg::OneQ30) - p);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q   <= fprod[61:30];
      cos_q <= neg_q[fegd_pkg::CosLat-2] ? -$signed({1'b0, c}) : $signed({1'b0, c});
    end
  end

  assign cos_o = cos_q;

endmodule

### rtl/fegd_sqrt_cell.sv
module fegd_sqrt_cell (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [25:0] rem_i,
  input  logic [23:0] root_i,
  input  logic [47:0] rad_i,
  output logic [25:0] rem_o,
  output logic [23:0] root_o,
  output logic [47:0] rad_o
);

  logic [25:0] rem_n, trial;
  logic [25:0] rem_q;
  logic [23:0] root_q;
  logic [47:0] rad_q;

  always_comb begin
    rem_n = {rem_i[23:0], rad_i[47:46]};
    trial = {root_i, 2'b01};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q <= {rad_i[45:0], 2'b00};
      if (rem_n >= trial) begin
        rem_q  <= rem_n - trial;
        root_q <= {root_i[22:0], 1'b1};
      end else begin
        rem_q  <= rem_n;
        root_q <= {root_i[22:0], 1'b0};
      end
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign rad_o  = rad_q;

endmodule

### rtl/flat_earth_geo_distance.sv
// Each accepted input beat passes through every pipeline stage to its result on distance_o.
// Throughput: one point pair per cycle; the whole pipeline, input included,
// holds only while a result waits in the last stage under out_stall_i.
// Depth is set by the cosine path (19 stages, five Horner cells of three each)
// and the square-root chain (24 cells, one root bit each). Reset clears all
// stage valid bits.
module flat_earth_geo_distance (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [23:0]       lat_a_i,
  input  logic signed [24:0]       lon_a_i,
  input  logic signed [23:0]       lat_b_i,
  input  logic signed [24:0]       lon_b_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [22:0]              distance_o
);

  localparam int Last = fegd_pkg::NumStages - 1;

  logic adv;
  logic [fegd_pkg::NumStages-1:0] vld_q;

  assign adv         = !(vld_q[Last] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[Last];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Last-1:0], in_valid_i};
    end
  end

  // differences, delayed to meet the cosines
  logic signed [24:0] dlat_s;
  logic signed [25:0] dlon_s;
  logic [24:0] dlat_d [fegd_pkg::CosLat];
  logic [25:0] dlon_d [fegd_pkg::CosLat];

  always_comb begin
    dlat_s = 25'(lat_a_i) - 25'(lat_b_i);
    dlon_s = 26'(lon_a_i) - 26'(lon_b_i);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dlat_d[0] <= dlat_s[24] ? 25'(-dlat_s) : 25'(dlat_s);
      dlon_d[0] <= dlon_s[25] ? 26'(-dlon_s) : 26'(dlon_s);
      for (int i = 1; i < fegd_pkg::CosLat; i++) begin
        dlat_d[i] <= dlat_d[i-1];
        dlon_d[i] <= dlon_d[i-1];
      end
    end
  end

  logic signed [31:0] cos_a, cos_b;

  fegd_cos u_cos_a (.clk_i(clk_i), .en_i(adv), .lat_i(lat_a_i), .cos_o(cos_a));
  fegd_cos u_cos_b (.clk_i(clk_i), .en_i(adv), .lat_i(lat_b_i), .cos_o(cos_b));

  logic signed [32:0] csum_s;
  logic [55:0] ns_prod;
  logic [56:0] ew_prod;
  logic [32:0] csum_q;
  logic [23:0] ns_q;
  logic [33:0] pd_q;
  logic [66:0] ewf;
  logic [23:0] ns_c_q, ew_c_q;
  logic [47:0] ns_sq_q, ew_sq_q, sum_q;

  always_comb begin
    csum_s  = 33'(cos_a) + 33'(cos_b);
    ns_prod = 56'(dlat_d[fegd_pkg::CosLat-1]) * 56'(fegd_pkg::MilesPerDegQ24);
    ew_prod = 57'(dlon_d[fegd_pkg::CosLat-1]) * 57'(fegd_pkg::MilesPerDegQ24);
    ewf     = 67'(pd_q) * 67'(csum_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      csum_q  <= csum_s[32] ? 33'(-csum_s) : 33'(csum_s);
      ns_q    <= ns_prod[55:32];
      pd_q    <= ew_prod[56:23];
      ns_c_q  <= (ns_q > fegd_pkg::LegCap) ? fegd_pkg::LegCap : ns_q;
      ew_c_q  <= (ewf[66:40] > 27'(fegd_pkg::LegCap)) ? fegd_pkg::LegCap : ewf[63:40];
      ns_sq_q <= 48'(ns_c_q) * 48'(ns_c_q);
      ew_sq_q <= 48'(ew_c_q) * 48'(ew_c_q);
      sum_q   <= ns_sq_q + ew_sq_q;
    end
  end

  logic [25:0] rem_c  [fegd_pkg::SqrtSteps+1];
  logic [23:0] root_c [fegd_pkg::SqrtSteps+1];
  logic [47:0] rad_c  [fegd_pkg::SqrtSteps+1];

  assign rem_c[0]  = '0;
  assign root_c[0] = '0;
  assign rad_c[0]  = sum_q;

  for (genvar i = 0; i < fegd_pkg::SqrtSteps; i++) begin : g_sqrt
    fegd_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rem_i  (rem_c[i]),
      .root_i (root_c[i]),
      .rad_i  (rad_c[i]),
      .rem_o  (rem_c[i+1]),
      .root_o (root_c[i+1]),
      .rad_o  (rad_c[i+1])
    );
  end

  logic [22:0] dist_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q <= root_c[fegd_pkg::SqrtSteps][23] ? fegd_pkg::DistMax
                                                : root_c[fegd_pkg::SqrtSteps][22:0];
    end
  end

  assign distance_o = dist_q;

  // cosine stays within one in magnitude
  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[fegd_pkg::CosLat-1] |-> (cos_a <= 32'sh4000_0000 && cos_a >= -32'sh4000_0000))
    else $error("cosine out of range");

  // a held pipeline keeps every stage valid bit
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved while held");

  // an accepted beat enters the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted beat lost");

  // neither the east-west nor the north-south leg exceeds the cap
  a_leg_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[fegd_pkg::CosLat+1] |-> (ew_c_q <= fegd_pkg::LegCap && ns_c_q <= fegd_pkg::LegCap))
    else $error("leg above cap");

endmodule

### verif/flat_earth_geo_distance_tb.sv
`timescale 1ns / 100ps

module flat_earth_geo_distance_tb;

  localparam int LatMax     = 5898240;
  localparam int LonMax     = 11796480;
  localparam int IdleLimit  = 20000;
  localparam int LatencyPad = 120;

  typedef struct {
    logic signed [fegd_pkg::LatW-1:0] lat_a;
    logic signed [fegd_pkg::LonW-1:0] lon_a;
    logic signed [fegd_pkg::LatW-1:0] lat_b;
    logic signed [fegd_pkg::LonW-1:0] lon_b;
  } point_pair_t;

  // distance predictor and store of expected distances
  class distance_board;
    logic [fegd_pkg::DistW-1:0] pending_dist[$];
    int unsigned mismatches = 0;

    function automatic longint cosine_q30(longint unsigned mag);
      longint unsigned full, half, quarter, x, rad, x2, t, p, c;
      longint unsigned divs[5];
      bit neg;
      divs = '{132, 90, 56, 30, 12};
      full = 64'd360 << fegd_pkg::AngleFracBits;
      half = 64'd180 << fegd_pkg::AngleFracBits;
      quarter = 64'd90 << fegd_pkg::AngleFracBits;
      neg = 1'b0;
      x = mag % full;
      if (x > half) x = full - x;
      if (x > quarter) begin
        x = half - x;
        neg = 1'b1;
      end
      rad = (x * 64'(fegd_pkg::DegToRadQ32)) >> (fegd_pkg::AngleFracBits + 2);
      x2 = (rad * rad) >> 30;
      t = 64'(fegd_pkg::OneQ30);
      for (int i = 0; i < 5; i++) t = 64'(fegd_pkg::OneQ30) - ((x2 * t) >> 30) / divs[i];
      p = ((x2 * t) >> 30) / 2;
      c = (p >= 64'(fegd_pkg::OneQ30)) ? 64'd0 : 64'(fegd_pkg::OneQ30) - p;
      return neg ? -longint'(c) : longint'(c);
    endfunction

    function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned s);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
        if (s >= root + bitv) begin
          s -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    function automatic logic [fegd_pkg::DistW-1:0] predict_distance(point_pair_t pp);
      longint la, oa, lb, ob;
      longint unsigned dlat, dlon, csum, ns, ew, d;
      la = pp.lat_a;
      oa = pp.lon_a;
      lb = pp.lat_b;
      ob = pp.lon_b;
      dlat = magnitude(la - lb);
      dlon = magnitude(oa - ob);
      csum = magnitude(cosine_q30(magnitude(la)) + cosine_q30(magnitude(lb)));
      ns = (dlat * 64'(fegd_pkg::MilesPerDegQ24))
           >> (fegd_pkg::AngleFracBits + 24 - fegd_pkg::DistFracBits);
      ew = (((dlon * 64'(fegd_pkg::MilesPerDegQ24)) >> 23) * csum)
           >> (fegd_pkg::AngleFracBits + 32 - fegd_pkg::DistFracBits);
      if (ns > 64'(fegd_pkg::LegCap)) ns = 64'(fegd_pkg::LegCap);
      if (ew > 64'(fegd_pkg::LegCap)) ew = 64'(fegd_pkg::LegCap);
      d = floor_sqrt(ns * ns + ew * ew);
      if (d > 64'(fegd_pkg::DistMax)) d = 64'(fegd_pkg::DistMax);
      return d[fegd_pkg::DistW-1:0];
    endfunction

    function void note_pair(point_pair_t pp);
      pending_dist.push_back(predict_distance(pp));
    endfunction

    function void check_distance(logic [fegd_pkg::DistW-1:0] got);
      logic [fegd_pkg::DistW-1:0] want;
      if (pending_dist.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected distance beat: %0d", got);
        return;
      end
      want = pending_dist.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("distance: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  logic signed [fegd_pkg::LatW-1:0] lat_a_i = '0;
  logic signed [fegd_pkg::LonW-1:0] lon_a_i = '0;
  logic signed [fegd_pkg::LatW-1:0] lat_b_i = '0;
  logic signed [fegd_pkg::LonW-1:0] lon_b_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b1;
  logic [fegd_pkg::DistW-1:0]       distance_o;

  distance_board board = new();
  point_pair_t   pairs[$];
  bit            idle_free = 1'b0;
  bit            hold_off = 1'b0;
  int unsigned   quiet_cycles = 0;

  flat_earth_geo_distance DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic signed [fegd_pkg::LatW-1:0] rand_lat();
    return fegd_pkg::LatW'($signed($urandom_range(2 * LatMax)) - LatMax);
  endfunction

  function automatic logic signed [fegd_pkg::LonW-1:0] rand_lon();
    return fegd_pkg::LonW'($signed($urandom_range(2 * LonMax)) - LonMax);
  endfunction

  // a quarter of pairs lie close together; the rest are two independent random points
  function automatic point_pair_t rand_pair();
    point_pair_t pp;
    int span;
    pp.lat_a = rand_lat();
    pp.lon_a = rand_lon();
    case ($urandom_range(3))
      0: begin
        span = 1 << $urandom_range(20);
        pp.lat_b = pp.lat_a + fegd_pkg::LatW'($signed($urandom_range(span)) - span / 2);
        pp.lon_b = pp.lon_a + fegd_pkg::LonW'($signed($urandom_range(span)) - span / 2);
        if (pp.lat_b > LatMax || pp.lat_b < -LatMax) pp.lat_b = pp.lat_a;
        if (pp.lon_b > LonMax || pp.lon_b < -LonMax) pp.lon_b = pp.lon_a;
      end
      default: begin
        pp.lat_b = rand_lat();
        pp.lon_b = rand_lon();
      end
    endcase
    return pp;
  endfunction

  function automatic point_pair_t make_pair(int la, int oa, int lb, int ob);
    point_pair_t pp;
    pp.lat_a = fegd_pkg::LatW'(la);
    pp.lon_a = fegd_pkg::LonW'(oa);
    pp.lat_b = fegd_pkg::LatW'(lb);
    pp.lon_b = fegd_pkg::LonW'(ob);
    return pp;
  endfunction

  task automatic send_pair(point_pair_t pp);
    lat_a_i <= pp.lat_a;
    lon_a_i <= pp.lon_a;
    lat_b_i <= pp.lat_b;
    lon_b_i <= pp.lon_b;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    board.note_pair(pp);
  endtask

  task automatic drive_pairs();
    int n;
    n = 0;
    foreach (pairs[i]) begin
      if (!idle_free && $urandom_range(99) < 32) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      send_pair(pairs[i]);
      n++;
      if (n == 400) begin
        // drain fully before continuing
        in_valid_i <= 1'b0;
        while (board.pending_dist.size() != 0) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_distance(distance_o);
      out_stall_i <= hold_off || (!idle_free && $urandom_range(99) < 32);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("flat_earth_geo_distance: mismatch");
      $finish;
    end
  end

  // receiver pressure: long hold-off, then a stretch with no idling at all
  initial begin
    wait (rst_ni);
    repeat (200) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
    repeat (300) @(posedge clk_i);
    idle_free = 1'b1;
    repeat (250) @(posedge clk_i);
    idle_free = 1'b0;
  end

  initial begin
    pairs.push_back(make_pair(0, 0, 0, 0));
    pairs.push_back(make_pair(LatMax, LonMax, -LatMax, -LonMax));
    pairs.push_back(make_pair(-LatMax, -LonMax, LatMax, LonMax));
    pairs.push_back(make_pair(0, -LonMax, 0, LonMax));
    pairs.push_back(make_pair(0, 0, LatMax, 0));
    pairs.push_back(make_pair(LatMax, 0, LatMax, LonMax));
    pairs.push_back(make_pair(0, 10 << 16, 0, 200 << 16));
    pairs.push_back(make_pair(45 << 16, 0, -45 << 16, 190 << 16));
    pairs.push_back(make_pair(1, 1, -1, -1));
    pairs.push_back(make_pair(-1, -1, 0, 0));
    pairs.push_back(make_pair(60 << 16, -LonMax, -60 << 16, LonMax));
    pairs.push_back(make_pair(LatMax - 1, 5, LatMax, 4));
    pairs.push_back(make_pair(30 << 16, 100 << 16, 30 << 16, -100 << 16));
    // full-range bit coverage of the port fields
    pairs.push_back(make_pair(-(1 << 23), -(1 << 24), (1 << 23) - 1, (1 << 24) - 1));
    pairs.push_back(make_pair((1 << 23) - 1, (1 << 24) - 1, -(1 << 23), -(1 << 24)));
    pairs.push_back(make_pair(-(1 << 23), 0, -(1 << 23), 0));
    pairs.push_back(make_pair(100 << 16, 0, -100 << 16, 50 << 16));
    repeat (950) pairs.push_back(rand_pair());

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    drive_pairs();
    while (board.pending_dist.size() != 0) @(posedge clk_i);
    repeat (LatencyPad) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_dist.size() == 0)
      $display("flat_earth_geo_distance: match");
    else
      $display("flat_earth_geo_distance: mismatch");
    $finish;
  end

endmodule
